// File: rtl/core/dequ_pkg.sv
// shared constants and types of the double-ended queue unit
`default_nettype none

package dequ_pkg;

    // default number of slots in the ring store
    localparam int unsigned DQ_CAPACITY = 16;

    // payload widths
    localparam int unsigned MODE_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 5;

    // operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

    // outcome of one operation, from the pointer logic to the top level
    typedef struct packed {
        logic ok;
        logic we;
    } t_step_flags;

endpackage

`default_nettype wire

// File: rtl/core/dequ_req_if.sv
// request channel: one operation per transfer
`default_nettype none

interface dequ_req_if;
    import dequ_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dequ_rsp_if.sv
// response channel: one result per transfer
`default_nettype none

interface dequ_rsp_if;
    import dequ_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic                     ends_valid;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output ok, output front_value, output back_value,
                    output ends_valid, output occupancy, input ready);
    modport sink   (input valid, input ok, input front_value, input back_value,
                    input ends_valid, input occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dequ_ram.sv
// ring store: one write port and two registered read ports
`default_nettype none

module dequ_ram #(
    parameter int unsigned CAPACITY = dequ_pkg::DQ_CAPACITY,
    parameter int unsigned AW       = $clog2(CAPACITY)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [AW-1:0]                      i_waddr,
    input  wire logic signed [dequ_pkg::DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                      i_raddr_a,
    input  wire logic [AW-1:0]                      i_raddr_b,
    output logic signed [dequ_pkg::DATA_W-1:0]      o_rdata_a,
    output logic signed [dequ_pkg::DATA_W-1:0]      o_rdata_b
);
    import dequ_pkg::*;

    logic signed [DATA_W-1:0] r_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rdata_a;
    logic signed [DATA_W-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// File: rtl/core/dequ_ptr.sv
// head index and element count of the ring, with the address arithmetic
`default_nettype none

module dequ_ptr #(
    parameter int unsigned CAPACITY = dequ_pkg::DQ_CAPACITY,
    parameter int unsigned AW       = $clog2(CAPACITY),
    parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [dequ_pkg::MODE_W-1:0]   i_mode,
    output dequ_pkg::t_step_flags              o_flags,
    output logic [AW-1:0]                      o_waddr,
    output logic [AW-1:0]                      o_front_addr,
    output logic [AW-1:0]                      o_back_addr,
    output logic [CW-1:0]                      o_count
);
    import dequ_pkg::*;

    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [AW:0]   CAP_EXT   = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;

    logic          full;
    logic          empty;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_addr;
    logic [AW:0]   back_sum;
    t_step_flags   flags;

    // full and empty flags, neighbouring slots of the head and the first free slot behind the back
    always_comb begin
        full      = (r_count == CAP_CNT);
        empty     = (r_count == '0);
        head_dec  = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
        head_inc  = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
        tail_sum  = {1'b0, r_head} + (AW + 1)'(r_count);
        tail_addr = (tail_sum >= CAP_EXT) ? AW'(tail_sum - CAP_EXT) : AW'(tail_sum);
    end

    // operation decode
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        flags.ok = 1'b0;
        flags.we = 1'b0;
        o_waddr  = tail_addr;
        unique case (i_mode)
            MODE_PUSH_FRONT: begin
                o_waddr = head_dec;
                if (!full) begin
                    n_head   = head_dec;
                    n_count  = r_count + CW'(1);
                    flags.ok = 1'b1;
                    flags.we = 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (!full) begin
                    n_count  = r_count + CW'(1);
                    flags.ok = 1'b1;
                    flags.we = 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (!empty) begin
                    n_head   = head_inc;
                    n_count  = r_count - CW'(1);
                    flags.ok = 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (!empty) begin
                    n_count  = r_count - CW'(1);
                    flags.ok = 1'b1;
                end
            end
            MODE_PEEK: begin
                flags.ok = 1'b1;
            end
            default: begin
                flags.ok = 1'b0;
            end
        endcase
    end

    // pointer registers, updated on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // slot of the back element, meaningful only when not empty
    always_comb begin
        back_sum    = {1'b0, r_head} + (AW + 1)'(r_count) - (AW + 1)'(1);
        o_back_addr = (back_sum >= CAP_EXT) ? AW'(back_sum - CAP_EXT) : AW'(back_sum);
    end

    assign o_flags      = '{ok: flags.ok, we: flags.we & i_step};
    assign o_front_addr = r_head;
    assign o_count      = r_count;

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue_unit.sv
// top level of the double-ended queue unit
//
//   port    dir  role      payload
//   i_req   in   sink      mode, value
//   o_rsp   out  source    ok, front_value, back_value, ends_valid, occupancy
//
// The request transfer writes the store and updates the pointers, the S_READ state
// reads both ends and the S_LOAD state loads the result register once the output is
// free; a new request is taken only after the result of the last one has been loaded.
// Reset empties the queue; store contents are not cleared.
// A stalled response holds the result; the next request may already be taken.
`default_nettype none

module double_ended_queue_unit #(
    parameter int unsigned CAPACITY = dequ_pkg::DQ_CAPACITY
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dequ_req_if.sink   i_req,
    dequ_rsp_if.source o_rsp
);
    import dequ_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    t_state                   r_state;
    logic                     r_ok;
    logic                     r_valid;
    logic                     r_res_ok;
    logic signed [DATA_W-1:0] r_front;
    logic signed [DATA_W-1:0] r_back;
    logic                     r_ends;
    logic [OCC_W-1:0]         r_occ;

    logic                     accept;
    logic                     out_free;
    logic                     not_empty;
    t_step_flags              w_flags;
    logic [AW-1:0]            w_waddr;
    logic [AW-1:0]            w_front_addr;
    logic [AW-1:0]            w_back_addr;
    logic [CW-1:0]            w_count;
    logic signed [DATA_W-1:0] w_front_data;
    logic signed [DATA_W-1:0] w_back_data;

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_valid || o_rsp.ready;
    assign not_empty = (w_count != '0);

    // head and count
    dequ_ptr #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ptr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_mode       (i_req.mode),
        .o_flags      (w_flags),
        .o_waddr      (w_waddr),
        .o_front_addr (w_front_addr),
        .o_back_addr  (w_back_addr),
        .o_count      (w_count)
    );

    // element store
    dequ_ram #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_flags.we),
        .i_waddr   (w_waddr),
        .i_wdata   (i_req.value),
        .i_raddr_a (w_front_addr),
        .i_raddr_b (w_back_addr),
        .o_rdata_a (w_front_data),
        .o_rdata_b (w_back_data)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && (r_state != S_LOAD)) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ok    <= w_flags.ok;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_valid  <= 1'b1;
                        r_res_ok <= r_ok;
                        r_front  <= not_empty ? w_front_data : '0;
                        r_back   <= not_empty ? w_back_data : '0;
                        r_ends   <= not_empty;
                        r_occ    <= OCC_W'(w_count);
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_valid;
    assign o_rsp.ok          = r_res_ok;
    assign o_rsp.front_value = r_front;
    assign o_rsp.back_value  = r_back;
    assign o_rsp.ends_valid  = r_ends;
    assign o_rsp.occupancy   = r_occ;

`ifndef SYNTH
    // count never exceeds the ring size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    // a refused operation leaves the count alone
    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !w_flags.ok) |=> (w_count == $past(w_count)))
        else $error("refused operation changed the count");

    // every transfer reaches the load state by way of the read state
    a_load_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 (r_state == S_LOAD))
        else $error("read sequence out of step");

    // an empty result carries zero ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ends) |-> (r_front == '0 && r_back == '0 && r_occ == '0))
        else $error("empty result with non-zero ends");

    // the store is written only on a transfer
    a_write_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flags.we |-> (accept && w_flags.ok))
        else $error("store written outside a transfer");
`endif

endmodule

`default_nettype wire

// File: test/double_ended_queue_unit_tb.sv
// self-checking testbench of the double-ended queue unit with an in-bench predictor
`default_nettype none

module double_ended_queue_unit_tb;
    import dequ_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES = 10;

    // one result as seen on the response channel
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic                     ends_valid;
        logic [OCC_W-1:0]         occupancy;
    } deque_result_t;

    // ring-store predictor and queue of expected results
    class deque_scoreboard;
        logic signed [DATA_W-1:0] ring[DQ_CAPACITY];
        int unsigned head = 0;
        int unsigned count = 0;
        deque_result_t expected_q[$];
        int errors = 0;

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted operation and queue its result
        function void note_request(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
            deque_result_t r;
            r = '0;
            case (mode)
                MODE_PUSH_FRONT: begin
                    if (count < DQ_CAPACITY) begin
                        head = (head + DQ_CAPACITY - 1) % DQ_CAPACITY;
                        ring[head] = value;
                        count++;
                        r.ok = 1'b1;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (count < DQ_CAPACITY) begin
                        ring[(head + count) % DQ_CAPACITY] = value;
                        count++;
                        r.ok = 1'b1;
                    end
                end
                MODE_POP_FRONT: begin
                    if (count != 0) begin
                        head = (head + 1) % DQ_CAPACITY;
                        count--;
                        r.ok = 1'b1;
                    end
                end
                MODE_POP_BACK: begin
                    if (count != 0) begin
                        count--;
                        r.ok = 1'b1;
                    end
                end
                MODE_PEEK: begin
                    r.ok = 1'b1;
                end
                default: begin
                    r.ok = 1'b0;
                end
            endcase
            // both ends read as zero when empty
            if (count != 0) begin
                r.front_value = ring[head];
                r.back_value  = ring[(head + count - 1) % DQ_CAPACITY];
                r.ends_valid  = 1'b1;
            end
            r.occupancy = count[OCC_W-1:0];
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] got);
            if (exp !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
            end
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(deque_result_t got);
            deque_result_t exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            exp = expected_q[0];
            expected_q.delete(0);
            compare_field("ok", exp.ok, got.ok);
            compare_field("front_value", exp.front_value, got.front_value);
            compare_field("back_value", exp.back_value, got.back_value);
            compare_field("ends_valid", exp.ends_valid, got.ends_valid);
            compare_field("occupancy", exp.occupancy, got.occupancy);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int unsigned cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    deque_scoreboard sb;

    dequ_req_if req_ch ();
    dequ_rsp_if rsp_ch ();

    double_ended_queue_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // clock
    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check each transfer, then choose ready for the next edge
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
                sb.check_result({rsp_ch.ok, rsp_ch.front_value, rsp_ch.back_value,
                                 rsp_ch.ends_valid, rsp_ch.occupancy});
            end
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one operation, with random idle cycles first, until it is taken
    task automatic send_op(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.value <= value;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(mode, value);
    endtask

    // stop offering and wait for every expected result
    task automatic wait_empty();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return '1;
            default: return $signed($urandom);
        endcase
    endfunction

    // mostly pushes or pops by the given bias, with peeks and unused codes mixed in
    function automatic logic [MODE_W-1:0] pick_mode(int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) return MODE_W'($urandom_range(MODE_PEEK + 1, (1 << MODE_W) - 1));
        if (r < 11) return MODE_PEEK;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    task automatic send_random(int unsigned n);
        int unsigned push_pct;
        push_pct = 50;
        for (int unsigned i = 0; i < n; i++) begin
            // change the fill bias every few dozen operations
            if (i % 30 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            send_op(pick_mode(push_pct), pick_value());
        end
    endtask

    initial begin
        logic signed [DATA_W-1:0] fill_vals[4];
        sb = new;
        req_ch.valid = 1'b0;
        req_ch.mode  = MODE_PEEK;
        req_ch.value = '0;
        fill_vals = '{32'sh7fffffff, 32'sh80000000, 32'sh55555555, 32'shaaaaaaaa};

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, unused codes, fill past full, then pops
        send_op(MODE_PEEK, 32'sd5);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_POP_BACK, '1);
        for (int m = MODE_PEEK + 1; m < (1 << MODE_W); m++) begin
            send_op(MODE_W'(m), fill_vals[m % 4]);
        end
        for (int i = 0; i < DQ_CAPACITY + 1; i++) begin
            send_op((i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                    (i < 4) ? fill_vals[i] : ((i == 4) ? '0 : ((i == 5) ? '1 : $urandom)));
        end
        send_op(MODE_PEEK, '0);
        send_op(MODE_POP_BACK, '0);
        send_op(MODE_POP_FRONT, '0);

        // long hold-off on the result side while operations keep coming
        send_idle_pct = 17;
        recv_idle_pct = 45;
        hold_asks++;
        send_random(40);
        wait_empty();

        // random phases with different idling
        send_random(650);
        send_idle_pct = 45;
        recv_idle_pct = 17;
        send_random(650);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(650);
        req_ch.valid <= 1'b0;

        // drain
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: double_ended_queue_unit.f
rtl/core/dequ_pkg.sv
rtl/core/dequ_req_if.sv
rtl/core/dequ_rsp_if.sv
rtl/core/dequ_ram.sv
rtl/core/dequ_ptr.sv
rtl/core/double_ended_queue_unit.sv
test/double_ended_queue_unit_tb.sv
